>>> sv/svq_pkg.sv
// ----------------------------------------------------------------------------
// svq_pkg: shared types and constants of the split VQ nearest-codeword block
// Sizes of the codebook sets, element and distance widths, item kind codes,
// controller state and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
package svq_pkg;

  // Codebook geometry
  localparam int ELEM_BITS     = 16;
  localparam int SPLIT_DIM     = 4;
  localparam int NUM_SPLITS    = 4;
  localparam int LONG_ENTRIES  = 128;
  localparam int SHORT_ENTRIES = 64;

  localparam int SPLIT_W     = 2;
  localparam int IDX_W       = 7;
  localparam int CNT_W       = 8;
  localparam int LONG_IDX_W  = $clog2(LONG_ENTRIES);
  localparam int SHORT_IDX_W = $clog2(SHORT_ENTRIES);
  localparam int LONG_ADDR_W  = SPLIT_W + LONG_IDX_W;
  localparam int SHORT_ADDR_W = SPLIT_W + SHORT_IDX_W;
  localparam int LONG_DEPTH   = LONG_ENTRIES * NUM_SPLITS;
  localparam int SHORT_DEPTH  = SHORT_ENTRIES * NUM_SPLITS;

  // Datapath widths: a codeword word, a difference, a square and the sum
  localparam int CW_W   = ELEM_BITS * SPLIT_DIM;
  localparam int DIFF_W = ELEM_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int DIST_W = SQ_W + 2;

  // Item kind codes
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ENCODE = 2'd1;
  localparam logic [1:0] KIND_DECODE = 2'd2;

  localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(LONG_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_wr;
    logic start_enc;
    logic start_dec;
    logic scan;
    logic emit;
  } svq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } svq_status_t;

endpackage

>>> sv/svq_ctrl.sv
// ----------------------------------------------------------------------------
// svq_ctrl: controller of the split VQ nearest-codeword block
// Takes one item at a time, steps the codebook scan and hands the final
// result to the output register once the distance pipeline has drained.
// ----------------------------------------------------------------------------
module svq_ctrl import svq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_kind,
  input  svq_status_t status,
  output logic        in_stall,
  output svq_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = in_valid && (state_r == ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_ENCODE || in_kind == KIND_DECODE)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!status.pipe_busy && status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_wr   = accept && (in_kind == KIND_LOAD);
        cmd.start_enc = accept && (in_kind == KIND_ENCODE);
        cmd.start_dec = accept && (in_kind == KIND_DECODE);
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_WAIT: begin
        cmd.emit = !status.pipe_busy && status.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

>>> sv/svq_datapath.sv
// ----------------------------------------------------------------------------
// svq_datapath: codebook memories and distance pipeline
// Holds both codebook sets, the count register, the scan counter, a
// read / square / sum / compare pipeline and the output word register.
// ----------------------------------------------------------------------------
module svq_datapath import svq_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  svq_cmd_t                    cmd,
  output svq_status_t                 status,
  input  logic                        cfg_valid,
  input  logic [CNT_W-1:0]            cfg_active_entries,
  input  logic                        in_bank,
  input  logic [SPLIT_W-1:0]          in_split,
  input  logic [IDX_W-1:0]            in_entry,
  input  logic signed [ELEM_BITS-1:0] in_elem_0,
  input  logic signed [ELEM_BITS-1:0] in_elem_1,
  input  logic signed [ELEM_BITS-1:0] in_elem_2,
  input  logic signed [ELEM_BITS-1:0] in_elem_3,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [IDX_W-1:0]            out_index_out,
  output logic signed [ELEM_BITS-1:0] out_q_0,
  output logic signed [ELEM_BITS-1:0] out_q_1,
  output logic signed [ELEM_BITS-1:0] out_q_2,
  output logic signed [ELEM_BITS-1:0] out_q_3
);

  logic [CW_W-1:0] long_mem  [LONG_DEPTH];
  logic [CW_W-1:0] short_mem [SHORT_DEPTH];

  logic [CNT_W-1:0]   active_r;
  logic [CW_W-1:0]    tgt_r;
  logic [SPLIT_W-1:0] split_r;
  logic               use_short_r;
  logic [IDX_W-1:0]   scan_idx_r;
  logic [IDX_W-1:0]   scan_end_r;

  logic               v1_r, v2_r, v3_r;
  logic [IDX_W-1:0]   idx1_r, idx2_r, idx3_r;
  logic [CW_W-1:0]    rd_long_r, rd_short_r;
  logic [CW_W-1:0]    cw2_r, cw3_r;
  logic [SQ_W-1:0]    sq2_r [SPLIT_DIM];
  logic [DIST_W-1:0]  dist3_r;

  logic               first_r;
  logic [DIST_W-1:0]  best_sum_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [CW_W-1:0]    best_cw_r;

  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [CW_W-1:0]    out_cw_r;

  logic [CW_W-1:0]    in_cw;
  logic               use_short;
  logic [CNT_W-1:0]   cnt_lo;
  logic [CNT_W-1:0]   cnt;
  logic [IDX_W-1:0]   last_idx;
  logic [IDX_W-1:0]   dec_idx;
  logic [CW_W-1:0]    cw1;
  logic [SQ_W-1:0]    sq1 [SPLIT_DIM];
  logic [DIST_W-1:0]  dist2;

  assign in_cw = {in_elem_3, in_elem_2, in_elem_1, in_elem_0};

  // Active count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_valid) begin
      active_r <= cfg_active_entries;
    end
  end

  // Effective count: zero acts as one, the long set is capped at its size
  always_comb begin
    use_short = active_r <= CNT_W'(SHORT_ENTRIES);
    cnt_lo    = (active_r == '0) ? CNT_W'(1) : active_r;
    cnt       = (!use_short && cnt_lo > CNT_W'(LONG_ENTRIES)) ? CNT_W'(LONG_ENTRIES)
                                                              : cnt_lo;
    last_idx  = IDX_W'(cnt - CNT_W'(1));
    dec_idx   = (CNT_W'(in_entry) >= cnt) ? last_idx : in_entry;
  end

  // Codebook writes on a load word, out-of-range addresses are dropped
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      if (!in_bank) begin
        if (CNT_W'(in_entry) < CNT_W'(SHORT_ENTRIES)) begin
          short_mem[{in_split, in_entry[SHORT_IDX_W-1:0]}] <= in_cw;
        end
      end else begin
        if (CNT_W'(in_entry) < CNT_W'(LONG_ENTRIES)) begin
          long_mem[{in_split, in_entry[LONG_IDX_W-1:0]}] <= in_cw;
        end
      end
    end
  end

  // Codebook reads, one entry per scan cycle
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_long_r  <= long_mem[LONG_ADDR_W'({split_r, scan_idx_r[LONG_IDX_W-1:0]})];
      rd_short_r <= short_mem[SHORT_ADDR_W'({split_r, scan_idx_r[SHORT_IDX_W-1:0]})];
    end
  end

  // Item registers and scan counter; decode scans just its clamped index
  always_ff @(posedge clk) begin
    if (cmd.start_enc || cmd.start_dec) begin
      tgt_r       <= in_cw;
      split_r     <= in_split;
      use_short_r <= use_short;
      scan_idx_r  <= cmd.start_dec ? dec_idx : '0;
      scan_end_r  <= cmd.start_dec ? dec_idx : last_idx;
    end else if (cmd.scan) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Squared differences, one lane per element
  always_comb begin
    logic signed [DIFF_W-1:0] d;
    logic signed [SQ_W-1:0]   p;
    cw1 = use_short_r ? rd_short_r : rd_long_r;
    for (int j = 0; j < SPLIT_DIM; j++) begin
      d = $signed({tgt_r[j*ELEM_BITS+ELEM_BITS-1], tgt_r[j*ELEM_BITS +: ELEM_BITS]})
        - $signed({cw1[j*ELEM_BITS+ELEM_BITS-1], cw1[j*ELEM_BITS +: ELEM_BITS]});
      p = d * d;
      sq1[j] = $unsigned(p);
    end
  end

  // Sum of the squares
  always_comb begin
    dist2 = '0;
    for (int j = 0; j < SPLIT_DIM; j++) begin
      dist2 = dist2 + DIST_W'(sq2_r[j]);
    end
  end

  // Pipeline payload stages
  always_ff @(posedge clk) begin
    idx1_r  <= scan_idx_r;
    sq2_r   <= sq1;
    cw2_r   <= cw1;
    idx2_r  <= idx1_r;
    dist3_r <= dist2;
    cw3_r   <= cw2_r;
    idx3_r  <= idx2_r;
  end

  // Running minimum; strict compare keeps the earlier entry on a tie
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (cmd.start_enc || cmd.start_dec) begin
      first_r <= 1'b1;
    end else if (v3_r) begin
      first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && (first_r || dist3_r < best_sum_r)) begin
      best_sum_r <= dist3_r;
      best_idx_r <= idx3_r;
      best_cw_r  <= cw3_r;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r <= best_idx_r;
      out_cw_r  <= best_cw_r;
    end
  end

  // Status back to the controller
  assign status.scan_last = scan_idx_r == scan_end_r;
  assign status.pipe_busy = v1_r || v2_r || v3_r;
  assign status.out_free  = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_index_out = out_idx_r;
  assign out_q_0       = out_cw_r[0*ELEM_BITS +: ELEM_BITS];
  assign out_q_1       = out_cw_r[1*ELEM_BITS +: ELEM_BITS];
  assign out_q_2       = out_cw_r[2*ELEM_BITS +: ELEM_BITS];
  assign out_q_3       = out_cw_r[3*ELEM_BITS +: ELEM_BITS];

endmodule

>>> sv/split_vq_nearest_codeword.sv
// ----------------------------------------------------------------------------
// split_vq_nearest_codeword: split vector quantizer nearest-codeword search
// Loads codewords, finds the nearest active codeword of a target split, and
// looks up a codeword by index.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A load word gives no result. An encode
// word reads one codeword per cycle from the selected codebook memory,
// with N active entries: the word is taken, N reads follow, then three
// stages of square, sum and compare, and the result is handed to the output
// register. A decode word reads a single entry. The next word is taken as
// soon as the result is in the output register, even while that result is
// still stalled. The count register may be written whenever the block is
// idle; the codebooks hold no defined value until loaded.
module split_vq_nearest_codeword import svq_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CNT_W-1:0]            cfg_active_entries,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic                        in_bank,
  input  logic [SPLIT_W-1:0]          in_split,
  input  logic [IDX_W-1:0]            in_entry,
  input  logic signed [ELEM_BITS-1:0] in_elem_0,
  input  logic signed [ELEM_BITS-1:0] in_elem_1,
  input  logic signed [ELEM_BITS-1:0] in_elem_2,
  input  logic signed [ELEM_BITS-1:0] in_elem_3,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [IDX_W-1:0]            out_index_out,
  output logic signed [ELEM_BITS-1:0] out_q_0,
  output logic signed [ELEM_BITS-1:0] out_q_1,
  output logic signed [ELEM_BITS-1:0] out_q_2,
  output logic signed [ELEM_BITS-1:0] out_q_3
);

  svq_cmd_t    cmd;
  svq_status_t status;

  // The count register is always writable
  assign cfg_ready = 1'b1;

  svq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  svq_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_valid          (cfg_valid),
    .cfg_active_entries (cfg_active_entries),
    .in_bank            (in_bank),
    .in_split           (in_split),
    .in_entry           (in_entry),
    .in_elem_0          (in_elem_0),
    .in_elem_1          (in_elem_1),
    .in_elem_2          (in_elem_2),
    .in_elem_3          (in_elem_3),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_index_out      (out_index_out),
    .out_q_0            (out_q_0),
    .out_q_1            (out_q_1),
    .out_q_2            (out_q_2),
    .out_q_3            (out_q_3)
  );

endmodule

>>> sv/svq_checker.sv
// ----------------------------------------------------------------------------
// svq_port_checker: port-level checks of the split VQ nearest-codeword block
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
module svq_port_checker import svq_pkg::*; (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [1:0]                  in_kind,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [IDX_W-1:0]            out_index_out,
  input logic signed [ELEM_BITS-1:0] out_q_0
);

  // A stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_index_out) && $stable(out_q_0))
    else $error("result word changed while stalled");

  // An encode or decode word blocks the input until its result is produced
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_ENCODE || in_kind == KIND_DECODE)
    |=> in_stall)
    else $error("input taken during a search");

  // A load word finishes in the cycle it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == KIND_LOAD |=> !in_stall)
    else $error("load word held the input");

  // A new result appears together with the input opening again
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result raised while the input stays blocked");

  // Reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind split_vq_nearest_codeword svq_port_checker u_svq_port_checker (.*);

>>> tb/svq_checker.sv
// ----------------------------------------------------------------------------
// svq_checker: result predictor and scoreboard for the split VQ block
// Watches the configuration, input and result channels. It keeps its own
// copy of both codebook sets and the active count, predicts the result word
// of every encode and decode word, and compares each result field by field.
// ----------------------------------------------------------------------------
module svq_checker import svq_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [CNT_W-1:0]            cfg_active_entries,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic                        in_bank,
  input  logic [SPLIT_W-1:0]          in_split,
  input  logic [IDX_W-1:0]            in_entry,
  input  logic signed [ELEM_BITS-1:0] in_elem_0,
  input  logic signed [ELEM_BITS-1:0] in_elem_1,
  input  logic signed [ELEM_BITS-1:0] in_elem_2,
  input  logic signed [ELEM_BITS-1:0] in_elem_3,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [IDX_W-1:0]            out_index_out,
  input  logic signed [ELEM_BITS-1:0] out_q_0,
  input  logic signed [ELEM_BITS-1:0] out_q_1,
  input  logic signed [ELEM_BITS-1:0] out_q_2,
  input  logic signed [ELEM_BITS-1:0] out_q_3,
  output int                          mismatches,
  output int                          pending
);

  typedef logic signed [ELEM_BITS-1:0] elem_t;

  typedef struct packed {
    logic [IDX_W-1:0]     index;
    logic [ELEM_BITS-1:0] q0;
    logic [ELEM_BITS-1:0] q1;
    logic [ELEM_BITS-1:0] q2;
    logic [ELEM_BITS-1:0] q3;
  } vq_result_t;

  // Private copy of the block state.
  elem_t            long_cb  [LONG_DEPTH][SPLIT_DIM];
  elem_t            short_cb [SHORT_DEPTH][SPLIT_DIM];
  logic [CNT_W-1:0] active_count = ACTIVE_RESET;

  vq_result_t expected_results[$];
  vq_result_t oldest;
  int         mismatch_count = 0;

  assign mismatches = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // Apply one accepted input word: loads update the codebook copy, encode
  // and decode words push the result word they will cause.
  task automatic predict_word(input logic [1:0] kind, input logic bank,
                              input logic [SPLIT_W-1:0] split,
                              input logic [IDX_W-1:0] entry,
                              input elem_t e0, input elem_t e1,
                              input elem_t e2, input elem_t e3);
    elem_t                    tgt [SPLIT_DIM];
    elem_t                    cw_e;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SQ_W-1:0]   sq;
    logic [DIST_W-1:0]        sum_sq;
    logic [DIST_W-1:0]        best_sum;
    bit                       use_short;
    int                       eff;
    int                       base;
    int                       best;
    vq_result_t               res;
    tgt[0] = e0;
    tgt[1] = e1;
    tgt[2] = e2;
    tgt[3] = e3;
    case (kind)
      KIND_LOAD: begin
        // A short-set address beyond the set is dropped.
        if (bank == 1'b0) begin
          if (entry < SHORT_ENTRIES) begin
            for (int j = 0; j < SPLIT_DIM; j++) begin
              short_cb[split * SHORT_ENTRIES + entry][j] = tgt[j];
            end
          end
        end else begin
          for (int j = 0; j < SPLIT_DIM; j++) begin
            long_cb[split * LONG_ENTRIES + entry][j] = tgt[j];
          end
        end
      end
      KIND_ENCODE, KIND_DECODE: begin
        // A zero count acts as one; long counts saturate at the set size.
        use_short = (active_count <= SHORT_ENTRIES);
        eff = (active_count == 0) ? 1 : int'(active_count);
        if (!use_short && eff > LONG_ENTRIES) eff = LONG_ENTRIES;
        base = split * (use_short ? SHORT_ENTRIES : LONG_ENTRIES);
        if (kind == KIND_DECODE) begin
          best = (entry >= eff) ? eff - 1 : int'(entry);
        end else begin
          // Exact squared distance; the first entry of least distance wins.
          best = 0;
          best_sum = '0;
          for (int i = 0; i < eff; i++) begin
            sum_sq = '0;
            for (int j = 0; j < SPLIT_DIM; j++) begin
              cw_e = use_short ? short_cb[base + i][j] : long_cb[base + i][j];
              diff = tgt[j] - cw_e;
              sq = diff * diff;
              sum_sq = sum_sq + sq;
            end
            if (i == 0 || sum_sq < best_sum) begin
              best_sum = sum_sq;
              best = i;
            end
          end
        end
        res.index = IDX_W'(best);
        res.q0 = use_short ? short_cb[base + best][0] : long_cb[base + best][0];
        res.q1 = use_short ? short_cb[base + best][1] : long_cb[base + best][1];
        res.q2 = use_short ? short_cb[base + best][2] : long_cb[base + best][2];
        res.q3 = use_short ? short_cb[base + best][3] : long_cb[base + best][3];
        expected_results.push_back(res);
      end
      default: begin
        // The unused kind is ignored by the block.
      end
    endcase
  endtask

  // Sample all three channels at the rising edge. A result is matched first,
  // since a word accepted on the same edge cannot have produced it yet.
  always @(posedge clk) begin
    if (!rst_n) begin
      active_count = ACTIVE_RESET;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected, index %0d",
                                    out_index_out));
        end else begin
          oldest = expected_results.pop_front();
          check_field("index", out_index_out, oldest.index);
          check_field("q_0", out_q_0, $signed(oldest.q0));
          check_field("q_1", out_q_1, $signed(oldest.q1));
          check_field("q_2", out_q_2, $signed(oldest.q2));
          check_field("q_3", out_q_3, $signed(oldest.q3));
        end
      end
      if (cfg_valid && cfg_ready) begin
        active_count = cfg_active_entries;
      end
      if (in_valid && !in_stall) begin
        predict_word(in_kind, in_bank, in_split, in_entry,
                     in_elem_0, in_elem_1, in_elem_2, in_elem_3);
      end
    end
    pending <= expected_results.size();
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: top level of the split VQ nearest-codeword testbench
// Drives directed and random load, encode and decode words through several
// active-count settings, with bursty input and a patterned result stall.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb;
  import svq_pkg::*;

  localparam int RESULTS_PER_PHASE = 20;
  localparam int SETTLE_CYCLES     = 150;
  localparam int HOLD_CYCLES       = 1000;
  localparam int WATCHDOG_LIMIT    = 5000;

  localparam logic [1:0]           KIND_UNUSED = 2'd3;
  localparam logic [ELEM_BITS-1:0] ELEM_MAX    = 16'h7FFF;
  localparam logic [ELEM_BITS-1:0] ELEM_MIN    = 16'h8000;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CNT_W-1:0]            cfg_active_entries;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  in_kind;
  logic                        in_bank;
  logic [SPLIT_W-1:0]          in_split;
  logic [IDX_W-1:0]            in_entry;
  logic signed [ELEM_BITS-1:0] in_elem_0;
  logic signed [ELEM_BITS-1:0] in_elem_1;
  logic signed [ELEM_BITS-1:0] in_elem_2;
  logic signed [ELEM_BITS-1:0] in_elem_3;
  logic                        out_valid;
  logic                        out_stall;
  logic [IDX_W-1:0]            out_index_out;
  logic signed [ELEM_BITS-1:0] out_q_0;
  logic signed [ELEM_BITS-1:0] out_q_1;
  logic signed [ELEM_BITS-1:0] out_q_2;
  logic signed [ELEM_BITS-1:0] out_q_3;
  int                          mismatches;
  int                          pending;

  // Which codebook entries have been loaded, so no unwritten entry is read.
  bit               short_written [NUM_SPLITS][SHORT_ENTRIES];
  bit               long_written  [NUM_SPLITS][LONG_ENTRIES];
  logic [CNT_W-1:0] cur_count = ACTIVE_RESET;
  bit               pressure_req = 1'b0;
  int               burst_left = 0;
  int               idle_cycles = 0;

  always #5 clk = ~clk;

  split_vq_nearest_codeword dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_active_entries (cfg_active_entries),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_bank            (in_bank),
    .in_split           (in_split),
    .in_entry           (in_entry),
    .in_elem_0          (in_elem_0),
    .in_elem_1          (in_elem_1),
    .in_elem_2          (in_elem_2),
    .in_elem_3          (in_elem_3),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_index_out      (out_index_out),
    .out_q_0            (out_q_0),
    .out_q_1            (out_q_1),
    .out_q_2            (out_q_2),
    .out_q_3            (out_q_3)
  );

  svq_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_active_entries (cfg_active_entries),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_bank            (in_bank),
    .in_split           (in_split),
    .in_entry           (in_entry),
    .in_elem_0          (in_elem_0),
    .in_elem_1          (in_elem_1),
    .in_elem_2          (in_elem_2),
    .in_elem_3          (in_elem_3),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_index_out      (out_index_out),
    .out_q_0            (out_q_0),
    .out_q_1            (out_q_1),
    .out_q_2            (out_q_2),
    .out_q_3            (out_q_3),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  // Element values lean on the extremes and on small values, which makes
  // equal distances and therefore ties common.
  function automatic logic [ELEM_BITS-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0:       return ELEM_MAX;
      1:       return ELEM_MIN;
      2:       return '0;
      3, 4:    return ELEM_BITS'($urandom_range(0, 15)) - ELEM_BITS'(8);
      default: return ELEM_BITS'($urandom);
    endcase
  endfunction

  function automatic bit short_selected();
    return cur_count <= SHORT_ENTRIES;
  endfunction

  // Entries searched under the current count.
  function automatic int searched_entries();
    if (cur_count == 0) return 1;
    if (cur_count > LONG_ENTRIES) return LONG_ENTRIES;
    return int'(cur_count);
  endfunction

  function automatic bit entry_loaded(input int split, input int idx);
    if (short_selected()) return short_written[split][idx];
    return long_written[split][idx];
  endfunction

  // Lowest searched entry of a split that has not been loaded, or -1.
  function automatic int first_hole(input int split);
    for (int i = 0; i < searched_entries(); i++) begin
      if (!entry_loaded(split, i)) return i;
    end
    return -1;
  endfunction

  // Offer one word from a falling edge and hold it until accepted, then
  // apply the burst and gap pattern of the sender.
  task automatic send_word(input logic [1:0] kind, input logic bank,
                           input logic [SPLIT_W-1:0] split,
                           input logic [IDX_W-1:0] entry,
                           input logic [ELEM_BITS-1:0] e0,
                           input logic [ELEM_BITS-1:0] e1,
                           input logic [ELEM_BITS-1:0] e2,
                           input logic [ELEM_BITS-1:0] e3);
    int gap;
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_bank   <= bank;
    in_split  <= split;
    in_entry  <= entry;
    in_elem_0 <= e0;
    in_elem_1 <= e1;
    in_elem_2 <= e2;
    in_elem_3 <= e3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == KIND_LOAD) begin
      if (bank == 1'b0 && entry < SHORT_ENTRIES) short_written[split][entry] = 1'b1;
      if (bank == 1'b1) long_written[split][entry] = 1'b1;
    end
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_load(input logic bank, input logic [SPLIT_W-1:0] split,
                           input logic [IDX_W-1:0] entry);
    send_word(KIND_LOAD, bank, split, entry, rand_elem(), rand_elem(), rand_elem(),
              rand_elem());
  endtask

  // Stop offering, wait for every expected result, then let the block settle.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the active count while the block is idle.
  task automatic write_count(input logic [CNT_W-1:0] value);
    drain_block();
    @(negedge clk);
    cfg_valid          <= 1'b1;
    cfg_active_entries <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_count = value;
  endtask

  // One random word. Encode and decode words whose reads would touch an
  // unloaded entry are replaced by the load that fills the hole.
  task automatic random_item(input logic [NUM_SPLITS-1:0] mask, output int made);
    int split;
    int roll;
    int hole;
    int idx;
    logic [IDX_W-1:0] entry;
    made = 0;
    do split = $urandom_range(0, NUM_SPLITS - 1); while (!mask[split]);
    roll = $urandom_range(0, 99);
    hole = first_hole(split);
    if (roll < 5) begin
      // Noise: the unused kind, or a load beyond the short set.
      if ($urandom_range(0, 1) == 0) begin
        send_word(KIND_UNUSED, 1'($urandom), SPLIT_W'($urandom), IDX_W'($urandom),
                  rand_elem(), rand_elem(), rand_elem(), rand_elem());
      end else begin
        send_load(1'b0, SPLIT_W'($urandom), IDX_W'($urandom_range(SHORT_ENTRIES, 127)));
      end
    end else if (roll < 30) begin
      if (hole >= 0 && $urandom_range(0, 1) == 0) begin
        send_load(short_selected() ? 1'b0 : 1'b1, SPLIT_W'(split), IDX_W'(hole));
      end else begin
        send_load(1'($urandom), SPLIT_W'($urandom), IDX_W'($urandom));
      end
    end else if (roll < 70) begin
      if (hole >= 0) begin
        send_load(short_selected() ? 1'b0 : 1'b1, SPLIT_W'(split), IDX_W'(hole));
      end else begin
        send_word(KIND_ENCODE, 1'($urandom), SPLIT_W'(split), IDX_W'($urandom),
                  rand_elem(), rand_elem(), rand_elem(), rand_elem());
        made = 1;
      end
    end else begin
      if ($urandom_range(0, 1) == 0) begin
        entry = IDX_W'($urandom_range(0, searched_entries() - 1));
      end else begin
        entry = IDX_W'($urandom);
      end
      idx = (entry >= searched_entries()) ? searched_entries() - 1 : int'(entry);
      if (!entry_loaded(split, idx)) begin
        send_load(short_selected() ? 1'b0 : 1'b1, SPLIT_W'(split), IDX_W'(idx));
      end else begin
        send_word(KIND_DECODE, 1'($urandom), SPLIT_W'(split), entry,
                  rand_elem(), rand_elem(), rand_elem(), rand_elem());
        made = 1;
      end
    end
  endtask

  // One count setting: a register write, then random words on the splits
  // of the mask until enough result words have been caused.
  task automatic run_phase(input logic [CNT_W-1:0] value,
                           input logic [NUM_SPLITS-1:0] mask, input bit with_hold);
    int results;
    int made;
    write_count(value);
    if (with_hold) pressure_req = 1'b1;
    results = 0;
    while (results < RESULTS_PER_PHASE) begin
      random_item(mask, made);
      results += made;
    end
  endtask

  // Receiver: stretches of no stall, random stall and heavy stall, plus one
  // long hold-off on request so the block backs up into its input.
  initial begin
    int mode;
    int span;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(negedge clk);
        if (pressure_req) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          pressure_req = 1'b0;
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Watchdog on cycles in which no word moves on any channel.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    rst_n              = 1'b0;
    cfg_valid          = 1'b0;
    cfg_active_entries = '0;
    in_valid           = 1'b0;
    in_kind            = KIND_LOAD;
    in_bank            = 1'b0;
    in_split           = '0;
    in_entry           = '0;
    in_elem_0          = '0;
    in_elem_1          = '0;
    in_elem_2          = '0;
    in_elem_3          = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset count selects the long set: decode its last entry of split 3.
    send_word(KIND_LOAD, 1'b1, 2'd3, 7'd127, 16'h5555, 16'hAAAA, ELEM_MAX, ELEM_MIN);
    send_word(KIND_DECODE, 1'b0, 2'd3, 7'd127, '0, '0, '0, '0);

    // Four short entries: both extremes and a pair of equal zero words.
    write_count(8'd4);
    send_word(KIND_LOAD, 1'b0, 2'd0, 7'd0, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
    send_word(KIND_LOAD, 1'b0, 2'd0, 7'd1, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
    send_word(KIND_LOAD, 1'b0, 2'd0, 7'd2, '0, '0, '0, '0);
    send_word(KIND_LOAD, 1'b0, 2'd0, 7'd3, '0, '0, '0, '0);
    // Ignored words: short load out of range and the unused kind.
    send_word(KIND_LOAD, 1'b0, 2'd0, 7'd100, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
    send_word(KIND_UNUSED, 1'b1, 2'd0, 7'd0, ELEM_MAX, ELEM_MIN, '0, '0);
    // Encodes: exact hits, the largest distance, and a tie to the earlier word.
    send_word(KIND_ENCODE, 1'b0, 2'd0, 7'd0, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
    send_word(KIND_ENCODE, 1'b1, 2'd0, 7'd127, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
    send_word(KIND_ENCODE, 1'b0, 2'd0, 7'd0, '0, '0, '0, '0);
    send_word(KIND_ENCODE, 1'b0, 2'd0, 7'd0, 16'd1, 16'hFFFF, 16'd2, 16'hFFFE);
    send_word(KIND_ENCODE, 1'b0, 2'd0, 7'd0, ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN);
    // Decodes in range and clamped to the last active entry.
    send_word(KIND_DECODE, 1'b0, 2'd0, 7'd0, '0, '0, '0, '0);
    send_word(KIND_DECODE, 1'b0, 2'd0, 7'd3, '0, '0, '0, '0);
    send_word(KIND_DECODE, 1'b0, 2'd0, 7'd4, '0, '0, '0, '0);
    send_word(KIND_DECODE, 1'b0, 2'd0, 7'd127, '0, '0, '0, '0);

    // A zero count behaves as a count of one.
    write_count(8'd0);
    send_word(KIND_DECODE, 1'b0, 2'd0, 7'd127, '0, '0, '0, '0);
    send_word(KIND_ENCODE, 1'b0, 2'd0, 7'd0, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);

    // Random phases over short, long and saturated counts.
    run_phase(8'd1,   4'hF, 1'b1);
    run_phase(8'd64,  4'h1, 1'b0);
    run_phase(8'd65,  4'h4, 1'b0);
    run_phase(8'd128, 4'h4, 1'b0);
    run_phase(8'd255, 4'h4, 1'b0);
    run_phase(8'd0,   4'hF, 1'b0);
    run_phase(8'd17,  4'hF, 1'b0);
    run_phase(8'd100, 4'h4, 1'b0);
    run_phase(8'd2,   4'hF, 1'b0);

    drain_block();
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/svq_pkg.sv
sv/svq_ctrl.sv
sv/svq_datapath.sv
sv/split_vq_nearest_codeword.sv
sv/svq_checker.sv
tb/svq_checker.sv
tb/tb.sv
